FILE: src/ppc_pkg.sv
// Shared constants, command codes and status codes of the priority collection unit.
package ppc_pkg;

	localparam int CAPACITY_DEFAULT       = 64;
	localparam int DATA_WIDTH_DEFAULT     = 32;
	localparam int PRIORITY_WIDTH_DEFAULT = 16;

	localparam int CMD_W      = 3;
	localparam int ID_W       = 6;
	localparam int PAYLOAD_W  = 32;
	localparam int RES_DATA_W = 32;
	localparam int RES_PRIO_W = 16;
	localparam int STATUS_W   = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD      = 3'd0,
		CMD_PROMOTE  = 3'd1,
		CMD_GET_MAX  = 3'd2,
		CMD_POP_MAX  = 3'd3,
		CMD_IS_VALID = 3'd4,
		CMD_GET      = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_EMPTY  = 2'd2,
		STAT_BAD_ID = 2'd3
	} status_t;

endpackage

FILE: src/ppc_if.sv
// Request and response channel interfaces of the priority collection unit.
interface ppc_req_if;
	import ppc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [ID_W-1:0]      entry_id;
	logic [PAYLOAD_W-1:0] payload;
	modport source(output valid, command, entry_id, payload, input ready);
	modport sink(input valid, command, entry_id, payload, output ready);
endinterface

interface ppc_rsp_if;
	import ppc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [ID_W-1:0]       result_id;
	logic [RES_DATA_W-1:0] result_data;
	logic [RES_PRIO_W-1:0] result_priority;
	logic                  is_live;
	logic [STATUS_W-1:0]   status;
	modport source(output valid, result_id, result_data, result_priority, is_live, status,
		input ready);
	modport sink(input valid, result_id, result_data, result_priority, is_live, status,
		output ready);
endinterface

FILE: src/ppc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/promotable_priority_collection_unit.sv
// Priority collection unit: a table of entries with add, promote, max query and pop.
// One request is handled at a time. After reset the unit first sweeps the priority
// memory to clear every live mark, with request.ready low. Add and unused commands go
// from acceptance straight to the response state; promote, is valid and get pass
// through an evaluation state first, since they read one entry from the memories. Get
// max and pop max scan: a single comparator walks the priority memory one entry
// per cycle, and the winner's data word is then read from the data memory. A finished
// response sits in an output register, so the next request may be accepted while it
// waits to be taken. Ids are handed out in order and never reused.
module promotable_priority_collection_unit #(
	parameter int CAPACITY       = ppc_pkg::CAPACITY_DEFAULT,
	parameter int DATA_WIDTH     = ppc_pkg::DATA_WIDTH_DEFAULT,
	parameter int PRIORITY_WIDTH = ppc_pkg::PRIORITY_WIDTH_DEFAULT
) (
	input logic      clk,
	input logic      arst_n,
	ppc_req_if.sink  request,
	ppc_rsp_if.source response
);
	import ppc_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = PRIORITY_WIDTH;
	localparam int DW = DATA_WIDTH;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_EVAL  = 7'b0000100,
		S_SCAN  = 7'b0001000,
		S_FETCH = 7'b0010000,
		S_FDATA = 7'b0100000,
		S_RESP  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [IW-1:0]    clr_q;
	logic [CW-1:0]    next_free_q;
	logic [CW-1:0]    scan_q;
	logic [CMD_W-1:0] cmd_q;
	logic [IW-1:0]    id_addr_q;
	logic             id_ok_q;

	logic [IW-1:0]    idx_s1;
	logic             v_s1;
	logic             found_q;
	logic [IW-1:0]    best_q;
	logic [PW-1:0]    best_prio_q;

	logic [ID_W-1:0]       res_id_q;
	logic [RES_DATA_W-1:0] res_data_q;
	logic [RES_PRIO_W-1:0] res_prio_q;
	logic                  res_live_q;
	logic [STATUS_W-1:0]   res_status_q;

	logic                  out_valid_q;
	logic [ID_W-1:0]       out_id_q;
	logic [RES_DATA_W-1:0] out_data_q;
	logic [RES_PRIO_W-1:0] out_prio_q;
	logic                  out_live_q;
	logic [STATUS_W-1:0]   out_status_q;

	// Each priority word carries the live mark above the priority.
	logic          prio_we;
	logic [IW-1:0] prio_waddr;
	logic [PW:0]   prio_wdata;
	logic [IW-1:0] prio_raddr;
	logic [PW:0]   prio_rdata;
	logic          data_we;
	logic [IW-1:0] data_waddr;
	logic [DW-1:0] data_wdata;
	logic [IW-1:0] data_raddr;
	logic [DW-1:0] data_rdata;

	logic accept;
	logic full;
	logic scan_done;
	logic entry_live;
	logic take;

	assign accept     = request.valid && request.ready;
	assign full       = (next_free_q == CW'(CAPACITY));
	assign scan_done  = (scan_q == CW'(CAPACITY));
	assign entry_live = id_ok_q && prio_rdata[PW];
	assign take       = v_s1 && prio_rdata[PW] &&
		(!found_q || (prio_rdata[PW-1:0] >= best_prio_q));

	assign request.ready            = (state_q == S_IDLE);
	assign response.valid           = out_valid_q;
	assign response.result_id       = out_id_q;
	assign response.result_data     = out_data_q;
	assign response.result_priority = out_prio_q;
	assign response.is_live         = out_live_q;
	assign response.status          = out_status_q;

	ppc_ram #(.WIDTH(PW + 1), .DEPTH(CAPACITY)) u_prio_ram (
		.clk  (clk),
		.we   (prio_we),
		.waddr(prio_waddr),
		.wdata(prio_wdata),
		.raddr(prio_raddr),
		.rdata(prio_rdata)
	);

	ppc_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_data_ram (
		.clk  (clk),
		.we   (data_we),
		.waddr(data_waddr),
		.wdata(data_wdata),
		.raddr(data_raddr),
		.rdata(data_rdata)
	);

	always_comb begin
		prio_we    = 1'b0;
		prio_waddr = '0;
		prio_wdata = '0;
		prio_raddr = id_addr_q;
		data_we    = 1'b0;
		data_waddr = next_free_q[IW-1:0];
		data_wdata = DW'(request.payload);
		data_raddr = id_addr_q;
		case (state_q)
			S_CLEAR: begin
				prio_we    = 1'b1;
				prio_waddr = clr_q;
			end
			S_IDLE: begin
				prio_raddr = IW'(request.entry_id);
				data_raddr = IW'(request.entry_id);
				if (accept && request.command == CMD_ADD && !full) begin
					prio_we    = 1'b1;
					prio_waddr = next_free_q[IW-1:0];
					prio_wdata = {1'b1, {PW{1'b0}}};
					data_we    = 1'b1;
				end
			end
			S_EVAL: begin
				if (cmd_q == CMD_PROMOTE && entry_live && prio_rdata[PW-1:0] != {PW{1'b1}}) begin
					prio_we    = 1'b1;
					prio_waddr = id_addr_q;
					prio_wdata = {1'b1, PW'(prio_rdata[PW-1:0] + 1'b1)};
				end
			end
			S_SCAN: begin
				prio_raddr = scan_done ? '0 : scan_q[IW-1:0];
			end
			S_FETCH: begin
				data_raddr = best_q;
			end
			S_FDATA: begin
				if (cmd_q == CMD_POP_MAX) begin
					prio_we    = 1'b1;
					prio_waddr = best_q;
					prio_wdata = {1'b0, best_prio_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			next_free_q  <= '0;
			scan_q       <= '0;
			cmd_q        <= '0;
			id_addr_q    <= '0;
			id_ok_q      <= 1'b0;
			idx_s1       <= '0;
			v_s1         <= 1'b0;
			found_q      <= 1'b0;
			best_q       <= '0;
			best_prio_q  <= '0;
			res_id_q     <= '0;
			res_data_q   <= '0;
			res_prio_q   <= '0;
			res_live_q   <= 1'b0;
			res_status_q <= STAT_OK;
			out_valid_q  <= 1'b0;
			out_id_q     <= '0;
			out_data_q   <= '0;
			out_prio_q   <= '0;
			out_live_q   <= 1'b0;
			out_status_q <= STAT_OK;
		end else begin
			if (out_valid_q && response.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= IW'(clr_q + 1'b1);
					if (clr_q == IW'(CAPACITY - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cmd_q        <= request.command;
						id_addr_q    <= IW'(request.entry_id);
						id_ok_q      <= (32'(request.entry_id) < 32'(next_free_q));
						res_id_q     <= '0;
						res_data_q   <= '0;
						res_prio_q   <= '0;
						res_live_q   <= 1'b0;
						res_status_q <= STAT_OK;
						case (request.command)
							CMD_ADD: begin
								if (full) begin
									res_status_q <= STAT_FULL;
								end else begin
									res_id_q    <= ID_W'(next_free_q);
									next_free_q <= CW'(next_free_q + 1'b1);
								end
								state_q <= S_RESP;
							end
							CMD_PROMOTE, CMD_IS_VALID, CMD_GET: begin
								state_q <= S_EVAL;
							end
							CMD_GET_MAX, CMD_POP_MAX: begin
								scan_q  <= '0;
								found_q <= 1'b0;
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_EVAL: begin
					case (cmd_q)
						CMD_IS_VALID: begin
							res_live_q <= entry_live;
						end
						CMD_GET: begin
							if (entry_live) begin
								res_data_q <= RES_DATA_W'(data_rdata);
								res_live_q <= 1'b1;
							end else begin
								res_status_q <= STAT_BAD_ID;
							end
						end
						default: begin
							if (!entry_live) begin
								res_status_q <= STAT_BAD_ID;
							end
						end
					endcase
					state_q <= S_RESP;
				end
				S_SCAN: begin
					// Reads are issued one per cycle; each is compared in the cycle after it is issued.
					if (scan_done) begin
						v_s1    <= 1'b0;
						state_q <= S_FETCH;
					end else begin
						idx_s1 <= scan_q[IW-1:0];
						v_s1   <= 1'b1;
						scan_q <= CW'(scan_q + 1'b1);
					end
				end
				S_FETCH: begin
					if (found_q) begin
						state_q <= S_FDATA;
					end else begin
						res_status_q <= STAT_EMPTY;
						state_q      <= S_RESP;
					end
				end
				S_FDATA: begin
					res_id_q   <= ID_W'(best_q);
					res_data_q <= RES_DATA_W'(data_rdata);
					res_prio_q <= RES_PRIO_W'(best_prio_q);
					state_q    <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || response.ready) begin
						out_valid_q  <= 1'b1;
						out_id_q     <= res_id_q;
						out_data_q   <= res_data_q;
						out_prio_q   <= res_prio_q;
						out_live_q   <= res_live_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// Ties go to the later entry, so an equal priority replaces the best so far.
			if (take) begin
				found_q     <= 1'b1;
				best_q      <= idx_s1;
				best_prio_q <= prio_rdata[PW-1:0];
			end
		end
	end
endmodule

FILE: src/ppc_checker.sv
// Port-level checks of the priority collection unit and their binding to it.
module ppc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [ppc_pkg::ID_W-1:0]       result_id,
	input logic [ppc_pkg::RES_DATA_W-1:0] result_data,
	input logic [ppc_pkg::RES_PRIO_W-1:0] result_priority,
	input logic                           is_live,
	input logic [ppc_pkg::STATUS_W-1:0]   status
);
	import ppc_pkg::*;

	// The clearing sweep keeps requests out right after reset.
	a_no_ready_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !req_ready)
		else $error("request ready right after reset release");

	// Only one request is in work at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in work");

	// Every failing response carries nothing but its status.
	a_error_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STAT_OK |->
		result_id == '0 && result_data == '0 && result_priority == '0 && !is_live)
		else $error("failing response carries field data");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_id) &&
		$stable(result_data) && $stable(result_priority) && $stable(is_live) &&
		$stable(status))
		else $error("stalled response changed");
endmodule

bind promotable_priority_collection_unit ppc_checker u_ppc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (request.valid),
	.req_ready      (request.ready),
	.rsp_valid      (response.valid),
	.rsp_ready      (response.ready),
	.result_id      (response.result_id),
	.result_data    (response.result_data),
	.result_priority(response.result_priority),
	.is_live        (response.is_live),
	.status         (response.status)
);
